/* rtl/contiguous_unit_allocator_top_macros.svh */
// Assertion macros for the unit allocator
`ifndef CONTIGUOUS_UNIT_ALLOCATOR_TOP_MACROS_SVH
`define CONTIGUOUS_UNIT_ALLOCATOR_TOP_MACROS_SVH
`define CUA_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("check failed");
`define CUA_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("check failed");
`endif

/* rtl/cua_pkg.sv */
// ---------------------------------------------------------------------------
// cua_pkg
// Types and constants shared by the unit allocator.
// ---------------------------------------------------------------------------
package cua_pkg;
  localparam int UNITS = 256;
  localparam int AW = 8;
  localparam int SW = 9;

  localparam logic [1:0] K_REQ = 2'd0;
  localparam logic [1:0] K_REL = 2'd1;
  localparam logic [1:0] K_CMP = 2'd2;
  localparam logic [1:0] K_RD  = 2'd3;

  localparam logic [1:0] F_FIRST = 2'd0;
  localparam logic [1:0] F_BEST  = 2'd1;
  localparam logic [1:0] F_WORST = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NFIT = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_FILL, S_REL, S_CMP, S_CLR, S_RD, S_OUT
  } state_t;

  // memory access from the sequencer
  typedef struct packed {
    logic          rd;
    logic [AW-1:0] raddr;
    logic          wr;
    logic [AW-1:0] waddr;
    logic [7:0]    wowner;
    logic          wfree;
  } mem_req_t;

  typedef struct packed {
    logic [7:0] owner;
    logic       free;
  } mem_rsp_t;
endpackage

/* rtl/cua_if.sv */
// ---------------------------------------------------------------------------
// cua_in_if / cua_out_if
// Valid/ready channels carrying command and result words.
// ---------------------------------------------------------------------------
interface cua_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] owner;
  logic [8:0] size;
  logic [1:0] fit;
  logic [7:0] address;
  modport source (output valid, kind, owner, size, fit, address, input ready);
  modport sink (input valid, kind, owner, size, fit, address, output ready);
endinterface

interface cua_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] base;
  logic [7:0] unit_owner;
  logic       unit_free;
  modport source (output valid, status, base, unit_owner, unit_free, input ready);
  modport sink (input valid, status, base, unit_owner, unit_free, output ready);
endinterface

/* rtl/cua_mem.sv */
// ---------------------------------------------------------------------------
// cua_mem
// Owner and free-mark table, one read and one write port, registered read.
// ---------------------------------------------------------------------------
module cua_mem
  import cua_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output mem_rsp_t rsp
);
  logic [8:0] mem [UNITS];

  always_ff @(posedge clk) begin
    if (req.wr) mem[req.waddr] <= {req.wowner, req.wfree};
    if (req.rd) {rsp.owner, rsp.free} <= mem[req.raddr];
  end
endmodule

/* rtl/cua_ctrl.sv */
// ---------------------------------------------------------------------------
// cua_ctrl
// Sequencer: hole scan, fill, release, compact, clear and read passes.
// ---------------------------------------------------------------------------
module cua_ctrl
  import cua_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  cua_in_if.sink      in_c,
  cua_out_if.source   out_c,
  output mem_req_t    req,
  input  mem_rsp_t    rsp
);
  `include "contiguous_unit_allocator_top_macros.svh"

  state_t state, state_next;
  logic [1:0] kind, fit;
  logic [7:0] own;
  logic [SW-1:0] need;
  logic [AW:0] rcnt, wcnt;    // read issue index, write index
  logic        rv;            // read data valid
  logic [AW-1:0] rva;         // address of data returning
  logic [AW:0] hstart, hlen, pick, plen;
  logic        found, any, clr_done;
  logic [1:0] o_status;
  logic [7:0] o_base, o_owner;
  logic       o_free;
  logic cur_free, scan_end, scan_ok, take;
  // result word held for the receiver
  logic [1:0] out_status;
  logic [7:0] out_base, out_owner;
  logic       out_free;

  assign in_c.ready = (state == S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLR: if (wcnt == (AW+1)'(UNITS-1)) state_next = (kind == K_CMP) ? S_OUT : S_IDLE;
      S_IDLE: if (in_c.valid && in_c.ready) begin
        case (in_c.kind)
          K_REQ: state_next = S_SCAN;
          K_REL: state_next = S_REL;
          K_CMP: state_next = S_CMP;
          default: state_next = S_RD;
        endcase
      end
      S_SCAN: if (rcnt == (AW+1)'(UNITS) && !rv && scan_end) state_next = scan_ok ? S_FILL : S_OUT;
      S_FILL: if (wcnt + 1'b1 == pick + need[AW:0] || wcnt == (AW+1)'(UNITS-1))
        state_next = S_OUT;
      S_REL: if (rcnt == (AW+1)'(UNITS) && !rv) state_next = S_OUT;
      // a full pool leaves nothing to clear
      S_CMP: if (rcnt == (AW+1)'(UNITS) && !rv)
        state_next = (wcnt == (AW+1)'(UNITS)) ? S_OUT : S_CLR;
      S_RD: if (rv) state_next = S_OUT;
      S_OUT: if (!out_c.valid || out_c.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // scan evaluation of returned word; trailing hole closed by sentinel
  assign scan_end = (rcnt == (AW+1)'(UNITS)) && !rv;
  assign cur_free = rv && rsp.free;
  always_comb begin
    take = 1'b0;
    if ((!cur_free) && (rv || scan_end) && hlen != '0 && {1'b0, hlen} >= {1'b0, need}) begin
      if (!found) take = 1'b1;
      else if (fit == F_BEST && hlen < plen) take = 1'b1;
      else if (fit == F_WORST && hlen > plen) take = 1'b1;
    end
  end
  assign scan_ok = found || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      kind <= K_RD;
      wcnt <= '0;
      rcnt <= '0;
      rv <= 1'b0;
      out_c.valid <= 1'b0;
    end else begin
      state <= state_next;
      rv <= req.rd;
      rva <= req.raddr;
      if (state == S_OUT && state_next == S_IDLE) out_c.valid <= 1'b1;
      else if (out_c.ready) out_c.valid <= 1'b0;
      case (state)
        S_CLR: wcnt <= wcnt + 1'b1;
        S_IDLE: begin
          rcnt <= '0; wcnt <= '0; hlen <= '0; found <= 1'b0; any <= 1'b0;
          kind <= in_c.kind; fit <= in_c.fit; own <= in_c.owner; need <= in_c.size;
          o_status <= ST_OK; o_base <= '0; o_owner <= '0; o_free <= 1'b0;
          if (in_c.valid && in_c.ready && in_c.kind == K_REQ &&
              (in_c.size == '0 || in_c.size > SW'(UNITS) || in_c.fit > F_WORST))
            rcnt <= (AW+1)'(UNITS);  // skip scan, reports no fit
          if (in_c.valid && in_c.ready && in_c.kind == K_RD) rcnt <= {1'b0, in_c.address};
        end
        S_SCAN: begin
          if (rcnt != (AW+1)'(UNITS)) rcnt <= rcnt + 1'b1;
          if (take) begin
            found <= 1'b1; pick <= hstart; plen <= hlen;
            if (fit == F_FIRST) rcnt <= (AW+1)'(UNITS);
          end
          if (cur_free) begin
            if (hlen == '0) hstart <= {1'b0, rva};
            hlen <= hlen + 1'b1;
          end else if (rv) hlen <= '0;
          if (take && fit == F_FIRST) hlen <= '0;
          if (state_next == S_FILL) begin
            wcnt <= take ? hstart : pick;
            if (take) pick <= hstart;
            o_base <= take ? hstart[AW-1:0] : pick[AW-1:0];
          end else if (state_next == S_OUT) o_status <= ST_NFIT;
        end
        S_FILL: wcnt <= wcnt + 1'b1;
        S_REL: begin
          if (rcnt != (AW+1)'(UNITS)) rcnt <= rcnt + 1'b1;
          if (rv && !rsp.free && rsp.owner == own) any <= 1'b1;
          if (state_next == S_OUT && !(any || (rv && !rsp.free && rsp.owner == own)))
            o_status <= ST_NONE;
        end
        S_CMP: begin
          if (rcnt != (AW+1)'(UNITS)) rcnt <= rcnt + 1'b1;
          if (rv && !rsp.free) wcnt <= wcnt + 1'b1;
        end
        S_RD: if (rv) begin
          o_owner <= rsp.free ? 8'd0 : rsp.owner;
          o_free <= rsp.free;
        end
        S_OUT: begin
          wcnt <= '0;
          if (state_next == S_IDLE) begin
            out_status <= o_status;
            out_base <= o_base;
            out_owner <= o_owner;
            out_free <= o_free;
          end
        end
        default: ;
      endcase
    end
  end

  assign clr_done = (state == S_CLR) && (wcnt == (AW+1)'(UNITS-1));

  // memory and output drive
  always_comb begin
    req = '0;
    case (state)
      S_SCAN, S_REL, S_CMP: begin
        req.rd = (rcnt != (AW+1)'(UNITS)) && !(state == S_SCAN && take && fit == F_FIRST);
        req.raddr = rcnt[AW-1:0];
      end
      S_RD: begin
        req.rd = !rv;
        req.raddr = rcnt[AW-1:0];
      end
      default: ;
    endcase
    case (state)
      S_CLR: begin
        req.wr = 1'b1; req.waddr = wcnt[AW-1:0]; req.wowner = '0; req.wfree = 1'b1;
      end
      S_FILL: begin
        req.wr = 1'b1; req.waddr = wcnt[AW-1:0]; req.wowner = own; req.wfree = 1'b0;
      end
      S_REL: begin
        req.wr = rv && !rsp.free && rsp.owner == own;
        req.waddr = rva; req.wowner = '0; req.wfree = 1'b1;
      end
      S_CMP: begin
        req.wr = rv && !rsp.free;
        req.waddr = wcnt[AW-1:0]; req.wowner = rsp.owner; req.wfree = 1'b0;
      end
      default: ;
    endcase
  end

  assign out_c.status = out_status;
  assign out_c.base = out_base;
  assign out_c.unit_owner = out_owner;
  assign out_c.unit_free = out_free;

  `CUA_ASSERT_IMP(a_ready_idle, in_c.ready, state == S_IDLE)
  `CUA_ASSERT_IMP(a_wr_scan, req.wr, state != S_SCAN && state != S_RD)
  `CUA_ASSERT_NEXT(a_out_after, state == S_OUT, out_c.valid)
  `CUA_ASSERT_IMP(a_clr_end, clr_done, state_next == S_IDLE || state_next == S_OUT)
endmodule

/* rtl/contiguous_unit_allocator_top.sv */
// ---------------------------------------------------------------------------
// contiguous_unit_allocator_top
// Contiguous run allocator over a 256-unit pool with first/best/worst fit.
// ---------------------------------------------------------------------------
// Usage: one command word in on cmd, one result word out on res, in order.
// A request scans the table once (first fit stops at the first hole that
// fits), then writes the granted units, one a cycle. A release or compact
// is one pass of reads with write-back; a compact then clears the units
// above the last used one, one a cycle. The single table memory port pair
// allows one read and one write a cycle. One command is in flight at a
// time. A finished result waits in the output register, so the next
// command is taken while the receiver stalls; that command then holds in
// its last cycle until the register is emptied, holding off cmd. After
// reset a clearing pass over all 256 units runs with cmd.ready low.
// ---------------------------------------------------------------------------
module contiguous_unit_allocator_top
  import cua_pkg::*;
(
  input logic       clk,
  input logic       rst,
  cua_in_if.sink    cmd,
  cua_out_if.source res
);
  mem_req_t req;
  mem_rsp_t rsp;

  cua_ctrl u_ctrl (.clk, .rst, .in_c(cmd), .out_c(res), .req, .rsp);
  cua_mem  u_mem  (.clk, .req, .rsp);
endmodule
